// ----- sv/loiter_lap_angle_tracker_assert.svh -----
// Assertion macros shared by the tracker checkers.
// No dependencies; clk and rst_n must be visible where the macros are used.
`ifndef LOITER_LAP_ANGLE_TRACKER_ASSERT_SVH
`define LOITER_LAP_ANGLE_TRACKER_ASSERT_SVH

// Checked only while out of reset.
`define LLAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LLAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/llat_pkg.sv -----
// Shared types and constants for the loiter lap angle tracker.
// No dependencies.
`timescale 1ns / 1ps

package llat_pkg;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_CCW_DIR      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LAP_INTERVAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ALT_TOL      = 2'd2;

  localparam logic [19:0] LAP_INTERVAL_RESET = 20'd108000;
  localparam logic [16:0] ALT_TOL_RESET      = 17'd500;

  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [15:0]        bearing_cd;
    logic               at_position;
    logic signed [31:0] altitude_cm;
    logic signed [31:0] goal_altitude_cm;
  } in_t;

  typedef struct packed {
    logic signed [31:0] angle_sum_cd;
    logic               alt_reached;
    logic               alt_unachievable;
  } out_t;

  typedef struct packed {
    logic        ccw_dir;
    logic [19:0] lap_interval_cd;
    logic [16:0] alt_tolerance_cm;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] angle_sum;
    logic [15:0]        previous_bearing;
    logic signed [31:0] lap_start_altitude;
    logic signed [31:0] next_check_sum;
    logic               reached;
    logic               unachievable;
  } state_t;

endpackage

// ----- sv/llat_step.sv -----
// Next-state logic for one navigation tick of the tracker.
// Depends on llat_pkg.
`timescale 1ns / 1ps

module llat_step (
  input  llat_pkg::in_t    item,
  input  llat_pkg::state_t st,
  input  llat_pkg::cfg_t   cfg,
  output llat_pkg::state_t st_nxt
);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v > 34'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [33:0] abs34(input logic signed [33:0] v);
    return (v < 0) ? -v : v;
  endfunction

  logic               sum_zero;
  logic signed [16:0] raw_d;
  logic signed [31:0] lap_base;
  logic signed [31:0] chk_base;
  logic [17:0]        shifted;
  logic [17:0]        rem;
  logic signed [16:0] wrap_d;
  logic signed [16:0] step_d;
  logic signed [31:0] new_sum;
  logic signed [33:0] abs_sum;
  logic signed [33:0] tol_x;
  logic signed [33:0] intv_x;
  logic               alt_ok;
  logic               lap_still;

  assign sum_zero = (st.angle_sum == 32'sd0);
  assign tol_x    = $signed(34'(cfg.alt_tolerance_cm));
  assign intv_x   = $signed(34'(cfg.lap_interval_cd));

  always_comb begin
    lap_base = st.lap_start_altitude;
    chk_base = st.next_check_sum;
    if (sum_zero && !item.at_position) begin
      raw_d = 17'sd0;
    end else if (sum_zero) begin
      raw_d    = 17'sd1;
      lap_base = item.altitude_cm;
      chk_base = $signed(32'(cfg.lap_interval_cd));
    end else begin
      raw_d = $signed({1'b0, item.bearing_cd}) - $signed({1'b0, st.previous_bearing});
    end
  end

  // bring into [0, 36000) then fold into (-18000, 18000]
  always_comb begin
    shifted = 18'(19'(raw_d) + 19'sd72000);
    if (shifted >= 18'd108000) begin
      rem = shifted - 18'd108000;
    end else if (shifted >= 18'd72000) begin
      rem = shifted - 18'd72000;
    end else if (shifted >= 18'd36000) begin
      rem = shifted - 18'd36000;
    end else begin
      rem = shifted;
    end
    if (rem > 18'd18000) begin
      wrap_d = 17'($signed({1'b0, rem}) - 19'sd36000);
    end else begin
      wrap_d = $signed(rem[16:0]);
    end
  end

  assign step_d  = cfg.ccw_dir ? -wrap_d : wrap_d;
  assign new_sum = sat32(34'(st.angle_sum) + 34'(step_d));
  assign abs_sum = abs34(34'(new_sum));

  assign alt_ok    = item.at_position &&
                     (abs34(34'(item.altitude_cm) - 34'(item.goal_altitude_cm)) < tol_x);
  assign lap_still = abs34(34'(item.altitude_cm) - 34'(lap_base)) < tol_x;

  always_comb begin
    st_nxt = st;
    if (item.command == llat_pkg::CMD_CLEAR) begin
      st_nxt.angle_sum    = 32'sd0;
      st_nxt.reached      = 1'b0;
      st_nxt.unachievable = 1'b0;
    end else begin
      st_nxt.previous_bearing   = item.bearing_cd;
      st_nxt.angle_sum          = new_sum;
      st_nxt.lap_start_altitude = lap_base;
      st_nxt.next_check_sum     = chk_base;
      if (alt_ok) begin
        st_nxt.reached        = 1'b1;
        st_nxt.unachievable   = 1'b0;
        st_nxt.next_check_sum = sat32(34'(new_sum) + intv_x);
      end else if (!st.reached && (abs_sum >= 34'(chk_base))) begin
        st_nxt.unachievable       = lap_still;
        st_nxt.lap_start_altitude = item.altitude_cm;
        st_nxt.next_check_sum     = sat32(34'(chk_base) + intv_x);
      end
    end
  end

endmodule

// ----- sv/loiter_lap_angle_tracker.sv -----
// Loiter lap angle tracker, top level.
// Input beat to result beat passes an input register, then a result register.
// Throughput: one beat per cycle while out_ready is high; the tracker state loop is closed by llat_step and state_r.
// Reset (rst_n low, synchronous): state cleared, config to defaults, both channels empty.
// Depends on llat_pkg and llat_step.
`timescale 1ns / 1ps

module loiter_lap_angle_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  llat_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output llat_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [llat_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [llat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  llat_pkg::cfg_t   cfg_r;
  llat_pkg::state_t state_r;
  llat_pkg::state_t state_nxt;
  llat_pkg::in_t    in_r;
  logic             in_v_r;
  logic             out_v_r;
  llat_pkg::out_t   out_r;
  logic             advance;
  logic             fire;

  assign advance  = !out_v_r || out_ready;
  assign fire     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  llat_step u_step (
    .item   (in_r),
    .st     (state_r),
    .cfg    (cfg_r),
    .st_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ccw_dir          <= 1'b0;
      cfg_r.lap_interval_cd  <= llat_pkg::LAP_INTERVAL_RESET;
      cfg_r.alt_tolerance_cm <= llat_pkg::ALT_TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        llat_pkg::REG_CCW_DIR:      cfg_r.ccw_dir          <= cfg_wdata[0];
        llat_pkg::REG_LAP_INTERVAL: cfg_r.lap_interval_cd  <= cfg_wdata;
        llat_pkg::REG_ALT_TOL:      cfg_r.alt_tolerance_cm <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (fire) begin
        state_r <= state_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r.angle_sum_cd     <= state_nxt.angle_sum;
      out_r.alt_reached      <= state_nxt.reached;
      out_r.alt_unachievable <= state_nxt.unachievable;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- sv/llat_checker.sv -----
// Port-level checks for loiter_lap_angle_tracker, bound to the top level.
// Depends on llat_pkg and loiter_lap_angle_tracker_assert.svh.
`timescale 1ns / 1ps
`include "loiter_lap_angle_tracker_assert.svh"

module llat_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input llat_pkg::out_t out_data
);

  `LLAT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while stalled")
  `LLAT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result beat right after reset")
  `LLAT_ASSERT(a_flags_excl, out_valid |-> !(out_data.alt_reached && out_data.alt_unachievable), "reached and unachievable both set")
  `LLAT_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind loiter_lap_angle_tracker llat_checker u_llat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb_loiter_lap_angle_tracker.sv -----
// Self-checking testbench for loiter_lap_angle_tracker: directed ticks, random loiter laps
// and half-turn runs, checked beat by beat against a built-in tracker predictor.
// Depends on llat_pkg and the loiter_lap_angle_tracker RTL.
`timescale 1ns / 1ps

module tb_loiter_lap_angle_tracker;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;
  localparam logic signed [31:0] ALT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] ALT_MIN = 32'sh80000000;
  localparam int CYCLE_LIMIT = 200000;

  class lap_score;
    logic              ccw = 1'b0;
    logic [19:0]       interval = llat_pkg::LAP_INTERVAL_RESET;
    logic [16:0]       tol = llat_pkg::ALT_TOL_RESET;
    logic signed [31:0] angle = '0;
    logic [15:0]       prev_bearing = '0;
    logic signed [31:0] lap_alt = '0;
    logic signed [31:0] next_check = '0;
    logic              reached = 1'b0;
    logic              unach = 1'b0;
    llat_pkg::out_t    tracker_outputs_due[$];
    int                mismatches = 0;

    function logic signed [31:0] clamp32(longint v);
      if (v > SUM_MAX) return ALT_MAX;
      if (v < SUM_MIN) return ALT_MIN;
      return v[31:0];
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint wrap_turn(longint d);
      longint r;
      r = d % 36000;
      if (r < 0) r += 36000;
      if (r > 18000) r -= 36000;
      return r;
    endfunction

    function void set_reg(logic [llat_pkg::CFG_ADDR_W-1:0] idx,
                          logic [llat_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        llat_pkg::REG_CCW_DIR: ccw = val[0];
        llat_pkg::REG_LAP_INTERVAL: interval = val;
        llat_pkg::REG_ALT_TOL: tol = val[16:0];
        default: ;
      endcase
    endfunction

    function int due_count();
      return tracker_outputs_due.size();
    endfunction

    function void note_tick(llat_pkg::in_t t);
      longint delta, step_dir, alt, goal;
      logic hit;
      llat_pkg::out_t o;
      alt = longint'($signed(t.altitude_cm));
      goal = longint'($signed(t.goal_altitude_cm));
      if (t.command == llat_pkg::CMD_CLEAR) begin
        angle = '0;
        reached = 1'b0;
        unach = 1'b0;
      end else begin
        step_dir = ccw ? -1 : 1;
        if (angle == 0 && !t.at_position) begin
          delta = 0;
        end else if (angle == 0) begin
          delta = 1;
          lap_alt = t.altitude_cm;
          next_check = clamp32(longint'(interval));
        end else begin
          delta = longint'(t.bearing_cd) - longint'(prev_bearing);
        end
        prev_bearing = t.bearing_cd;
        delta = wrap_turn(delta);
        angle = clamp32(longint'(angle) + delta * step_dir);
        hit = t.at_position && (mag(alt - goal) < longint'(tol));
        if (hit) begin
          reached = 1'b1;
          unach = 1'b0;
          next_check = clamp32(longint'(angle) + longint'(interval));
        end else if (!reached && mag(longint'(angle)) >= longint'(next_check)) begin
          unach = mag(alt - longint'(lap_alt)) < longint'(tol);
          lap_alt = t.altitude_cm;
          next_check = clamp32(longint'(next_check) + longint'(interval));
        end
      end
      o.angle_sum_cd = angle;
      o.alt_reached = reached;
      o.alt_unachievable = unach;
      tracker_outputs_due.push_back(o);
    endfunction

    function void check_output(llat_pkg::out_t got);
      llat_pkg::out_t want;
      if (tracker_outputs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing due: sum=%0d reached=%0b unach=%0b",
                   $time, got.angle_sum_cd, got.alt_reached, got.alt_unachievable);
        return;
      end
      want = tracker_outputs_due.pop_front();
      if (got.angle_sum_cd !== want.angle_sum_cd || got.alt_reached !== want.alt_reached ||
          got.alt_unachievable !== want.alt_unachievable) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp sum=%0d r=%0b u=%0b, got sum=%0d r=%0b u=%0b",
                   $time, want.angle_sum_cd, want.alt_reached, want.alt_unachievable,
                   got.angle_sum_cd, got.alt_reached, got.alt_unachievable);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  llat_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  llat_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [llat_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [llat_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  lap_score sb = new();
  int burst_left = 0;
  bit tx_idle_on = 1'b1;
  bit rx_steady = 1'b0;
  int cycles = 0;
  int rx_tick = 0;
  logic [15:0] rx_pat = 16'hFFFF;

  loiter_lap_angle_tracker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check the beat, then move the stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
    rx_tick++;
    if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_tick % 64 == 0)
        rx_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      out_ready <= rx_pat[0];
      rx_pat = {rx_pat[0], rx_pat[15:1]};
    end
  end

  function automatic llat_pkg::in_t mk(logic cmd, int unsigned b, logic p,
                                       logic signed [31:0] a, logic signed [31:0] g);
    llat_pkg::in_t t;
    t.command = cmd;
    t.bearing_cd = 16'(b);
    t.at_position = p;
    t.altitude_cm = a;
    t.goal_altitude_cm = g;
    return t;
  endfunction

  task automatic send_tick(llat_pkg::in_t t);
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic offer(llat_pkg::in_t t);
    if (burst_left <= 0) begin
      if (tx_idle_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_tick(t);
  endtask

  task automatic drain_tracker();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(logic ccw, logic [19:0] ivl, logic [16:0] tv);
    cfg_we <= 1'b1;
    cfg_addr <= llat_pkg::REG_CCW_DIR;
    cfg_wdata <= {19'd0, ccw};
    @(posedge clk);
    sb.set_reg(llat_pkg::REG_CCW_DIR, {19'd0, ccw});
    cfg_addr <= llat_pkg::REG_LAP_INTERVAL;
    cfg_wdata <= ivl;
    @(posedge clk);
    sb.set_reg(llat_pkg::REG_LAP_INTERVAL, ivl);
    cfg_addr <= llat_pkg::REG_ALT_TOL;
    cfg_wdata <= {3'd0, tv};
    @(posedge clk);
    sb.set_reg(llat_pkg::REG_ALT_TOL, {3'd0, tv});
    cfg_we <= 1'b0;
  endtask

  // one loiter: optional clear, approach, then steady circling with an altitude profile and random ticks mixed in
  task automatic loiter_run(int n);
    llat_pkg::in_t t;
    longint alt, goal, climb, hover;
    int b, stride, mode, wait_ticks;
    b = $urandom_range(0, 35999);
    if ($urandom_range(0, 9) == 0) goal = longint'(int'($urandom()));
    else goal = longint'($urandom_range(0, 2000000)) - 1000000;
    alt = goal + longint'($urandom_range(0, 400000)) - 200000;
    hover = alt;
    mode = $urandom_range(0, 2);
    climb = (goal - alt) / longint'($urandom_range(4, 40));
    stride = $urandom_range(200, 9000);
    if (sb.ccw) stride = -stride;
    if ($urandom_range(0, 5) == 0) stride = -stride;
    wait_ticks = $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 0)
      offer(mk(llat_pkg::CMD_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 1),
               $urandom(), $urandom()));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        t = mk($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 1),
               $urandom(), $urandom());
      end else begin
        b = (b + stride + int'($urandom_range(0, 200)) - 100) % 36000;
        if (b < 0) b += 36000;
        case (mode)
          0: alt = hover + longint'($urandom_range(0, sb.tol)) - longint'(sb.tol) / 2;
          1: alt = alt + climb;
          default: alt = alt + longint'($urandom_range(0, 20000)) - 10000;
        endcase
        if ($urandom_range(0, 29) == 0)
          alt = goal + longint'($urandom_range(0, sb.tol)) - longint'(sb.tol) / 2;
        t = mk(llat_pkg::CMD_UPDATE, b, (i >= wait_ticks) && ($urandom_range(0, 19) != 0),
               alt[31:0], goal[31:0]);
        if (b < 29536 && $urandom_range(0, 24) == 0) t.bearing_cd = 16'(b + 36000);
      end
      offer(t);
    end
  endtask

  // after a clear, half-turn steps every beat: past the first update the wrap lands exactly on 18000 each time
  task automatic sat_run(int n);
    int b;
    logic signed [31:0] a;
    b = $urandom_range(0, 35999);
    offer(mk(llat_pkg::CMD_CLEAR, b, 1'b0, 32'sd0, 32'sd0));
    for (int i = 0; i < n; i++) begin
      b = (b + 18000) % 36000;
      a = 32'sd1000000 + 32'($urandom_range(0, 999));
      if (i > n - 20 && $urandom_range(0, 19) == 0) a = 32'sd0;
      offer(mk(llat_pkg::CMD_UPDATE, b, 1'b1, a, 32'sd0));
    end
  endtask

  initial begin
    llat_pkg::in_t picks[$];
    int left, n, pick;
    logic pc;
    logic [19:0] ivl;
    logic [16:0] tv;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    picks.push_back(mk(llat_pkg::CMD_UPDATE, 0, 1'b0, 32'sd100, 32'sd1000000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 65535, 1'b0, ALT_MIN, ALT_MAX));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 35999, 1'b1, ALT_MAX, ALT_MIN));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 0, 1'b1, 32'sd0, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 18000, 1'b1, 32'sd0, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 0, 1'b1, 32'sd0, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 65535, 1'b1, 32'sd0, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 36000, 1'b1, 32'sd0, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 17999, 1'b1, 32'sd4501, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_CLEAR, 35999, 1'b1, ALT_MIN, ALT_MIN));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 100, 1'b0, 32'sd7, 32'sd7));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 100, 1'b1, 32'sd5500, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 200, 1'b1, ALT_MIN, ALT_MAX));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 54000, 1'b1, 32'sd4500, 32'sd5000));
    picks.push_back(mk(llat_pkg::CMD_UPDATE, 54000, 1'b1, 32'sd4000, 32'sd5000));
    foreach (picks[i]) offer(picks[i]);

    for (int k = 0; k < 14; k++) begin
      drain_tracker();
      case (k)
        0: apply_setting(1'b1, 20'd1, 17'd0);
        1: apply_setting(1'b0, 20'hFFFFF, 17'h1FFFF);
        2: apply_setting(1'b1, 20'd0, 17'd1);
        3: apply_setting(1'b0, 20'd1000000, 17'd100000);
        4: apply_setting(1'b1, llat_pkg::LAP_INTERVAL_RESET, llat_pkg::ALT_TOL_RESET);
        default: begin
          pc = $urandom_range(0, 1);
          pick = $urandom_range(0, 3);
          if (pick < 2) ivl = 20'($urandom_range(1, 40000));
          else if (pick == 2) ivl = 20'($urandom_range(1, 1000000));
          else ivl = $urandom_range(0, 1) ? 20'd1 : 20'd1000000;
          if ($urandom_range(0, 1)) tv = 17'($urandom_range(1, 3000));
          else tv = 17'($urandom_range(1, 100000));
          apply_setting(pc, ivl, tv);
        end
      endcase
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      left = 120;
      while (left > 0) begin
        n = $urandom_range(5, 60);
        if (n > left) n = left;
        loiter_run(n);
        left -= n;
      end
    end

    drain_tracker();
    apply_setting(1'b0, 20'd1000000, 17'd500);
    tx_idle_on = 1'b0;
    rx_steady = 1'b1;
    sat_run(60);
    drain_tracker();
    apply_setting(1'b1, 20'd1000, 17'd500);
    sat_run(60);
    drain_tracker();

    if (sb.mismatches == 0 && sb.due_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- loiter_lap_angle_tracker.f -----
+incdir+sv
sv/llat_pkg.sv
sv/llat_step.sv
sv/loiter_lap_angle_tracker.sv
sv/llat_checker.sv
tb/tb_loiter_lap_angle_tracker.sv
